@@ hdl/awt_pkg.sv @@
package awt_pkg;

   // Transfer geometry
   localparam int MAX_PACKETS   = 1024;
   localparam int PAYLOAD_BYTES = 14324;

   // Field widths
   localparam int ACK_W      = 24;
   localparam int PKT_CNT_W  = 11;
   localparam int WIN_W      = 10;
   localparam int BASE_OUT_W = 11;
   localparam int CNT_W      = 2;

   // Internal widths
   localparam int ADDR_W = $clog2(MAX_PACKETS);
   localparam int BASE_W = $clog2(MAX_PACKETS + 1);
   localparam int N_W    = (PKT_CNT_W > BASE_W) ? PKT_CNT_W : BASE_W;
   localparam int PAY_W  = $clog2(PAYLOAD_BYTES + 1);

   // Reciprocal for ack/payload: q_est = (x * RECIP) >> ACK_W is low by at most one
   localparam int RECIP_W = ACK_W + 1;
   localparam int PROD_W  = ACK_W + RECIP_W;
   localparam int QD_W    = ACK_W + PAY_W;
   localparam logic [RECIP_W-1:0] RECIP       = RECIP_W'((64'd1 << ACK_W) / PAYLOAD_BYTES);
   localparam logic [PAY_W-1:0]   PAYLOAD_VEC = PAY_W'(PAYLOAD_BYTES);
   localparam logic [ACK_W-1:0]   PAYLOAD_ACK = ACK_W'(PAYLOAD_BYTES);

   localparam logic [N_W-1:0] MAX_PACKETS_N = N_W'(MAX_PACKETS);

   // Per-packet acknowledgement count
   localparam logic [CNT_W-1:0] COUNT_MAX  = 2'd3;
   localparam logic [CNT_W-1:0] LOSS_LEVEL = 2'd2;

   // Configuration registers
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = PKT_CNT_W;
   localparam logic [CSR_ADDR_W-1:0] CSR_PACKET_COUNT = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_WINDOW_LIMIT = 1'b1;

   localparam logic [PKT_CNT_W-1:0] PACKET_COUNT_RESET = '0;
   localparam logic [WIN_W-1:0]     WINDOW_LIMIT_RESET = WIN_W'(100);
   localparam logic [WIN_W-1:0]     WINDOW_ONE         = WIN_W'(1);

endpackage

@@ hdl/awt_if.sv @@
interface awt_req_if import awt_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ACK_W-1:0] ack_bytes;

   modport source (output valid, output ack_bytes, input ready);
   modport sink   (input valid, input ack_bytes, output ready);
endinterface

interface awt_rsp_if import awt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [BASE_OUT_W-1:0] window_base;
   logic [WIN_W-1:0]      window_size;
   logic                  all_acked;
   logic                  loss_seen;
   logic                  ack_ignored;

   modport source (output valid, output window_base, output window_size,
                   output all_acked, output loss_seen, output ack_ignored, input ready);
   modport sink   (input valid, input window_base, input window_size,
                   input all_acked, input loss_seen, input ack_ignored, output ready);
endinterface

@@ hdl/awt_ram.sv @@
module awt_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/awt_ack_div.sv @@
module awt_ack_div import awt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [ACK_W-1:0] ack_bytes,
   output logic             done,
   output logic [ACK_W-1:0] pkt_index
);

   // pkt_index = (ack_bytes - 1) / PAYLOAD_BYTES, three stages:
   // latch, reciprocal multiply, back-multiply, then one correction step.
   logic [2:0]       vld_ff;
   logic [ACK_W-1:0] x_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [ACK_W-1:0] quot_ff;
   logic [QD_W-1:0]  qd_ff;
   logic [ACK_W-1:0] quot_in;
   logic [ACK_W-1:0] rem;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[1:0], start};
      end
   end

   assign quot_in = prod_ff[ACK_W +: ACK_W];

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff <= ack_bytes - ACK_W'(1);
      end
      prod_ff <= PROD_W'(x_ff) * PROD_W'(RECIP);
      quot_ff <= quot_in;
      qd_ff   <= QD_W'(quot_in) * QD_W'(PAYLOAD_VEC);
   end

   assign rem       = x_ff - qd_ff[ACK_W-1:0];
   assign done      = vld_ff[2];
   assign pkt_index = quot_ff + ACK_W'(rem >= PAYLOAD_ACK);

endmodule

@@ hdl/ack_window_tracker.sv @@
// Sender-side acknowledgement window tracker. Each request carries one
// cumulative byte acknowledgement; it maps to packet (ack-1)/PAYLOAD_BYTES,
// bumps that packet's saturating 2-bit count, grows the congestion window by
// one (up to window_limit) when the base packet is acknowledged, walks the
// base past acknowledged packets and halves the window (floor 1) on a third
// or later acknowledgement of a packet. One response per request. A zero
// acknowledgement or one beyond packet_count is flagged in ack_ignored and
// changes nothing. Timing: after reset a clearing pass writes all MAX_PACKETS
// (1024) count entries, one per cycle, and no request is taken until it
// ends. A request then passes through the divider; an accepted one also
// reads and rewrites its packet's count and walks the base: the count memory
// has one read port, so the base walk inspects one packet per cycle. A
// response waits in an output register and the next request is taken
// meanwhile. Write packet_count / window_limit only while idle.
module ack_window_tracker import awt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   awt_req_if.sink               req_chan,
   awt_rsp_if.source             rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // sequencer states
   localparam logic [2:0] ST_CLEAR   = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_DIV     = 3'd2;
   localparam logic [2:0] ST_UPD_RD  = 3'd3;
   localparam logic [2:0] ST_UPD_WR  = 3'd4;
   localparam logic [2:0] ST_WALK_RD = 3'd5;
   localparam logic [2:0] ST_WALK    = 3'd6;
   localparam logic [2:0] ST_FIN     = 3'd7;

   logic [2:0]            state_ff, state_in;
   logic [ADDR_W-1:0]     clr_addr_ff, clr_addr_in;
   logic [PKT_CNT_W-1:0]  pkt_count_ff;
   logic [WIN_W-1:0]      win_limit_ff;
   logic [BASE_W-1:0]     base_ff, base_in;
   logic [WIN_W-1:0]      cwnd_ff, cwnd_in;
   logic                  ack_zero_ff, ack_zero_in;
   logic [ADDR_W-1:0]     pkt_ff, pkt_in;
   logic                  loss_ff, loss_in;
   logic                  ignored_ff, ignored_in;
   logic                  first_ff, first_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BASE_OUT_W-1:0] rsp_base_ff;
   logic [WIN_W-1:0]      rsp_size_ff;
   logic                  rsp_all_ff, rsp_loss_ff, rsp_ign_ff;
   logic                  rsp_load;

   // count memory ports
   logic                  ram_wr_en;
   logic [ADDR_W-1:0]     ram_wr_addr;
   logic [CNT_W-1:0]      ram_wr_data;
   logic [ADDR_W-1:0]     ram_rd_addr;
   logic [CNT_W-1:0]      ram_rd_data;

   logic                  div_done;
   logic [ACK_W-1:0]      div_pkt;

   logic                  req_take;
   logic [N_W-1:0]        active_n;
   logic [N_W-1:0]        base_n;
   logic                  base_in_range;
   logic [CNT_W-1:0]      cnt_next;
   logic [WIN_W-1:0]      cwnd_half;
   logic [WIN_W-1:0]      cwnd_out;
   logic [BASE_W-1:0]     base_plus;

   // packets in use, saturated at MAX_PACKETS
   always_comb begin
      if (N_W'(pkt_count_ff) > MAX_PACKETS_N) begin
         active_n = MAX_PACKETS_N;
      end else begin
         active_n = N_W'(pkt_count_ff);
      end
   end

   assign base_n        = N_W'(base_ff);
   assign base_in_range = base_n < active_n;
   assign base_plus     = base_ff + BASE_W'(1);
   assign cnt_next      = (ram_rd_data == COUNT_MAX) ? COUNT_MAX : ram_rd_data + CNT_W'(1);
   assign cwnd_half     = (cwnd_ff >> 1) == '0 ? WINDOW_ONE : cwnd_ff >> 1;
   assign cwnd_out      = loss_ff ? cwnd_half : cwnd_ff;

   assign req_take       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   awt_ack_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (req_take),
      .ack_bytes (req_chan.ack_bytes),
      .done      (div_done),
      .pkt_index (div_pkt)
   );

   awt_ram #(
      .WIDTH (CNT_W),
      .DEPTH (MAX_PACKETS)
   ) u_counts (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_count_ff <= PACKET_COUNT_RESET;
         win_limit_ff <= WINDOW_LIMIT_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_PACKET_COUNT) begin
            pkt_count_ff <= csr_wdata;
         end else if (csr_index == CSR_WINDOW_LIMIT) begin
            win_limit_ff <= csr_wdata[WIN_W-1:0];
         end
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      base_in     = base_ff;
      cwnd_in     = cwnd_ff;
      ack_zero_in = ack_zero_ff;
      pkt_in      = pkt_ff;
      loss_in     = loss_ff;
      ignored_in  = ignored_ff;
      first_in    = first_ff;
      rsp_load    = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = pkt_ff;
      ram_wr_data = cnt_next;
      ram_rd_addr = pkt_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(MAX_PACKETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               ack_zero_in = (req_chan.ack_bytes == '0);
               loss_in     = 1'b0;
               state_in    = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               pkt_in = div_pkt[ADDR_W-1:0];
               if (ack_zero_ff || (div_pkt >= ACK_W'(active_n))) begin
                  ignored_in = 1'b1;
                  state_in   = ST_FIN;
               end else begin
                  ignored_in = 1'b0;
                  state_in   = ST_UPD_RD;
               end
            end
         end
         ST_UPD_RD: begin
            ram_rd_addr = pkt_ff;
            state_in    = ST_UPD_WR;
         end
         ST_UPD_WR: begin
            // read data is the count of pkt_ff; saturating increment
            ram_wr_en = 1'b1;
            loss_in   = cnt_next > LOSS_LEVEL;
            state_in  = ST_WALK_RD;
         end
         ST_WALK_RD: begin
            // write landed last cycle, so the base read sees it
            ram_rd_addr = base_ff[ADDR_W-1:0];
            first_in    = 1'b1;
            state_in    = ST_WALK;
         end
         ST_WALK: begin
            // read data is the count of base_ff
            if (base_in_range && ram_rd_data != '0) begin
               base_in     = base_plus;
               ram_rd_addr = base_plus[ADDR_W-1:0];
               first_in    = 1'b0;
               if (first_ff && cwnd_ff < win_limit_ff) begin
                  cwnd_in = cwnd_ff + WIN_W'(1);
               end
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               cwnd_in  = cwnd_out;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         base_ff     <= '0;
         cwnd_ff     <= WINDOW_ONE;
         loss_ff     <= 1'b0;
         ignored_ff  <= 1'b0;
         first_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         base_ff     <= base_in;
         cwnd_ff     <= cwnd_in;
         loss_ff     <= loss_in;
         ignored_ff  <= ignored_in;
         first_ff    <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      ack_zero_ff <= ack_zero_in;
      pkt_ff      <= pkt_in;
   end

   // response register: frees on take, refills from the sequencer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_base_ff <= BASE_OUT_W'(base_ff);
         rsp_size_ff <= cwnd_out;
         rsp_all_ff  <= !base_in_range;
         rsp_loss_ff <= loss_ff && !ignored_ff;
         rsp_ign_ff  <= ignored_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.window_base = rsp_base_ff;
   assign rsp_chan.window_size = rsp_size_ff;
   assign rsp_chan.all_acked   = rsp_all_ff;
   assign rsp_chan.loss_seen   = rsp_loss_ff;
   assign rsp_chan.ack_ignored = rsp_ign_ff;

endmodule

@@ test/ack_window_tracker_test.sv @@
module ack_window_tracker_test import awt_pkg::*; ();

   // Run bounds and pacing
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 20;    // quiet time after the last response
   localparam int HOLD_AT       = 400;   // response count that starts the long hold-off
   localparam int HOLD_CYCLES   = 300;
   localparam int MAX_GAP       = 13;
   localparam int MAX_REPORTS   = 50;    // cap on printed mismatches

   // One request waiting to be driven, plus the idle cycles after it is taken
   typedef struct packed {
      logic [ACK_W-1:0] ack;
      logic [3:0]       gap;
   } ack_req_type;

   // One response as the block should report it
   typedef struct packed {
      logic [BASE_OUT_W-1:0] window_base;
      logic [WIN_W-1:0]      window_size;
      logic                  all_acked;
      logic                  loss_seen;
      logic                  ack_ignored;
   } window_report_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_ADDR_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   awt_req_if req_if ();
   awt_rsp_if rsp_if ();

   ack_window_tracker dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow of the tracker: per-packet ack counts, base, window and registers
   logic [CNT_W-1:0]     seen_count [MAX_PACKETS];
   int                   pred_base;
   logic [WIN_W-1:0]     pred_window;
   logic [PKT_CNT_W-1:0] cfg_packets;
   logic [WIN_W-1:0]     cfg_limit;

   ack_req_type       ack_queue[$];        // requests not yet on the bus
   window_report_type pending_reports[$];  // responses owed by the block

   int acks_queued;
   int acks_taken;
   int reports_seen;
   int ignored_seen;
   int losses_seen;
   int errors;
   int cycles;
   int idle_left;
   int stall_left;
   int hold_left;
   bit calm;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Packet count actually in use: the register saturates at the table depth
   function automatic int active_packets();
      return (cfg_packets > MAX_PACKETS) ? MAX_PACKETS : int'(cfg_packets);
   endfunction

   // Apply one cumulative acknowledgement to the shadow and return the report.
   // Packet index is ceil(ack / payload) - 1, so a short last packet still maps.
   function automatic window_report_type track_ack(input logic [ACK_W-1:0] ack);
      window_report_type r;
      int n;
      int pkt;
      n = active_packets();
      r.loss_seen   = 1'b0;
      r.ack_ignored = 1'b0;
      if (ack == '0) begin
         r.ack_ignored = 1'b1;
      end else begin
         pkt = (int'(ack) + PAYLOAD_BYTES - 1) / PAYLOAD_BYTES - 1;
         if (pkt >= n) begin
            r.ack_ignored = 1'b1;
         end else begin
            if (seen_count[pkt] != COUNT_MAX)
               seen_count[pkt] = seen_count[pkt] + 1'b1;
            // additive increase only when the base packet itself is covered
            if (pred_base < n && seen_count[pred_base] != '0 && pred_window < cfg_limit)
               pred_window = pred_window + 1'b1;
            while (pred_base < n && seen_count[pred_base] != '0)
               pred_base++;
            // third or later ack of the packet: halve, floor at one
            if (seen_count[pkt] > LOSS_LEVEL) begin
               pred_window = pred_window >> 1;
               if (pred_window == '0)
                  pred_window = WINDOW_ONE;
               r.loss_seen = 1'b1;
            end
         end
      end
      r.window_base = BASE_OUT_W'(pred_base);
      r.window_size = pred_window;
      r.all_acked   = (pred_base >= n);
      return r;
   endfunction

   // Random byte offset inside packet pkt (first byte to last byte)
   function automatic logic [ACK_W-1:0] ack_in_packet(input int pkt);
      int unsigned lo;
      int unsigned hi;
      lo = pkt * PAYLOAD_BYTES + 1;
      hi = lo + PAYLOAD_BYTES - 1;
      if (hi > 32'hFFFFFF)
         hi = 32'hFFFFFF;
      return ACK_W'($urandom_range(hi, lo));
   endfunction

   task automatic push_ack(input logic [ACK_W-1:0] ack, input int gap);
      ack_req_type it;
      it.ack = ack;
      it.gap = 4'(gap);
      ack_queue.push_back(it);
      acks_queued++;
   endtask

   // Block until every queued request is taken and answered, then let the
   // block settle before anything else happens.
   task automatic wait_idle();
      do @(posedge clock);
      while (acks_taken != acks_queued || pending_reports.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write, only called with the block idle; shadow follows the write edge
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_PACKET_COUNT)
         cfg_packets = val;
      else
         cfg_limit = val[WIN_W-1:0];
   endtask

   // Mostly a plausible ack stream from the current base: in-order acks, short
   // duplicates, acks a little ahead of a hole. The rest is zero acks, acks past
   // the transfer and full-range noise.
   task automatic queue_transfer(input int items, input bit pause_midway);
      int n;
      int cursor;
      int pkt;
      int r;
      int gap_hi;
      logic [ACK_W-1:0] ack;
      n      = active_packets();
      cursor = pred_base;
      gap_hi = MAX_GAP;
      for (int i = 0; i < items; i++) begin
         if (i % 50 == 0)
            gap_hi = ($urandom_range(3, 0) == 0) ? 0 : MAX_GAP;
         // sender stops until every response of the first half is back
         if (pause_midway && i == items / 2)
            wait_idle();
         if (n != 0 && cursor >= n)
            cursor = $urandom_range(n - 1, 0);
         r = $urandom_range(99, 0);
         if (n == 0 || r >= 95) begin
            ack = ACK_W'($urandom);
         end else if (r < 55) begin
            ack = ack_in_packet(cursor);
            cursor++;
         end else if (r < 72) begin
            pkt = (cursor > 0) ? cursor - $urandom_range((cursor < 3) ? cursor : 3, 1) : 0;
            ack = ack_in_packet(pkt);
         end else if (r < 84) begin
            pkt = cursor + $urandom_range(8, 1);
            ack = ack_in_packet((pkt >= n) ? n - 1 : pkt);
         end else if (r < 89) begin
            ack = '0;
         end else begin
            ack = ACK_W'($urandom_range(32'hFFFFFF, n * PAYLOAD_BYTES + 1));
         end
         push_ack(ack, $urandom_range(gap_hi, 0));
      end
   endtask

   // Request driver: holds an item until taken, then idles for its gap
   always @(posedge clock) begin : drive_requests
      ack_req_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
         idle_left = 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (idle_left != 0) begin
            idle_left--;
            req_if.valid <= 1'b0;
         end else if (ack_queue.size() != 0) begin
            nxt = ack_queue.pop_front();
            req_if.valid     <= 1'b1;
            req_if.ack_bytes <= nxt.ack;
            idle_left = nxt.gap;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Monitor: predicts on each accepted request, checks each accepted response,
   // and paces the response ready (random stalls, calm stretches, one long hold).
   always @(posedge clock) begin : watch_channels
      window_report_type want;
      window_report_type got;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            pending_reports.push_back(track_ack(req_if.ack_bytes));
            acks_taken++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got.window_base = rsp_if.window_base;
            got.window_size = rsp_if.window_size;
            got.all_acked   = rsp_if.all_acked;
            got.loss_seen   = rsp_if.loss_seen;
            got.ack_ignored = rsp_if.ack_ignored;
            if (pending_reports.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: response with no request outstanding: base=%0d size=%0d",
                           $time, got.window_base, got.window_size);
            end else begin
               want = pending_reports.pop_front();
               if (want.ack_ignored) ignored_seen++;
               if (want.loss_seen)   losses_seen++;
               if (got.window_base !== want.window_base ||
                   got.window_size !== want.window_size ||
                   got.all_acked   !== want.all_acked   ||
                   got.loss_seen   !== want.loss_seen   ||
                   got.ack_ignored !== want.ack_ignored) begin
                  errors++;
                  if (errors <= MAX_REPORTS)
                     $display({"%0t: mismatch expected base=%0d size=%0d all=%b loss=%b ign=%b",
                               " actual base=%0d size=%0d all=%b loss=%b ign=%b"},
                              $time, want.window_base, want.window_size, want.all_acked,
                              want.loss_seen, want.ack_ignored, got.window_base,
                              got.window_size, got.all_acked, got.loss_seen,
                              got.ack_ignored);
               end
            end
            reports_seen++;
            if (reports_seen % 64 == 0)
               calm = ($urandom_range(3, 0) == 0);
            stall_left = calm ? 0 : $urandom_range(MAX_GAP, 0);
            // long hold-off so the output register and the input side back up
            if (reports_seen == HOLD_AT)
               hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d of %0d requests answered",
                  $time, reports_seen, acks_queued);
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.ack_bytes = '0;
      rsp_if.ready     = 1'b0;
      csr_wr_en        = 1'b0;
      csr_index        = CSR_PACKET_COUNT;
      csr_wdata        = '0;
      for (int i = 0; i < MAX_PACKETS; i++)
         seen_count[i] = '0;
      pred_base   = 0;
      pred_window = WINDOW_ONE;
      cfg_packets = PACKET_COUNT_RESET;
      cfg_limit   = WINDOW_LIMIT_RESET;
      calm        = 1'b0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset registers: empty transfer, so every request is ignored,
      // including a zero ack and the largest byte count.
      push_ack('0, $urandom_range(MAX_GAP, 0));
      push_ack('1, $urandom_range(MAX_GAP, 0));
      push_ack(ACK_W'(1), $urandom_range(MAX_GAP, 0));
      wait_idle();

      // Six packets, window capped at two
      write_csr(CSR_PACKET_COUNT, CSR_DATA_W'(6));
      write_csr(CSR_WINDOW_LIMIT, CSR_DATA_W'(2));
      push_ack(ACK_W'(1), 0);                          // first byte of packet 0
      push_ack(ACK_W'(PAYLOAD_BYTES), 1);              // last byte of packet 0, duplicate
      push_ack(ACK_W'(3 * PAYLOAD_BYTES), 0);          // packet 2 ahead of a hole
      push_ack(ACK_W'(PAYLOAD_BYTES + 1), 2);          // fills hole, growth hits the cap
      push_ack(ACK_W'(2 * PAYLOAD_BYTES), 0);          // packet 1 second time
      push_ack(ACK_W'(2 * PAYLOAD_BYTES), 0);          // third time: halve
      push_ack(ACK_W'(PAYLOAD_BYTES + 5), 3);          // saturated count, halve at floor
      push_ack(ACK_W'(6 * PAYLOAD_BYTES), 0);          // last packet of the transfer
      push_ack(ACK_W'(6 * PAYLOAD_BYTES + 1), 0);      // one byte past the transfer
      push_ack(ACK_W'(5 * PAYLOAD_BYTES - 7), 1);      // short read into packet 4
      push_ack(ACK_W'(3 * PAYLOAD_BYTES + 1), 0);      // base walks to the end
      push_ack('0, 0);
      wait_idle();

      // Grow the window freely over six more packets
      write_csr(CSR_PACKET_COUNT, CSR_DATA_W'(12));
      write_csr(CSR_WINDOW_LIMIT, CSR_DATA_W'(1023));
      for (int p = 6; p < 12; p++)
         push_ack(ack_in_packet(p), $urandom_range(MAX_GAP, 0));
      wait_idle();

      // Limit of zero below the current window: no growth, no cut until loss
      write_csr(CSR_WINDOW_LIMIT, CSR_DATA_W'(0));
      push_ack(ACK_W'(6 * PAYLOAD_BYTES + 1), 0);
      push_ack(ACK_W'(6 * PAYLOAD_BYTES + 1), 0);
      wait_idle();

      // Packet count lowered under the base: stays put, reports all acked
      write_csr(CSR_PACKET_COUNT, CSR_DATA_W'(4));
      push_ack(ACK_W'(2 * PAYLOAD_BYTES), 0);
      push_ack('0, 0);
      wait_idle();

      // Random transfers, each from wherever the base stands
      write_csr(CSR_PACKET_COUNT, CSR_DATA_W'(64));
      write_csr(CSR_WINDOW_LIMIT, CSR_DATA_W'($urandom_range(1023, 1)));
      queue_transfer(210, 1'b0);
      wait_idle();

      write_csr(CSR_PACKET_COUNT, CSR_DATA_W'(256));
      write_csr(CSR_WINDOW_LIMIT, CSR_DATA_W'(1));
      queue_transfer(210, 1'b0);
      wait_idle();

      write_csr(CSR_PACKET_COUNT, CSR_DATA_W'(512));
      write_csr(CSR_WINDOW_LIMIT, CSR_DATA_W'(1023));
      queue_transfer(210, 1'b1);
      wait_idle();

      // Count register above the table depth saturates to it
      write_csr(CSR_PACKET_COUNT, '1);
      write_csr(CSR_WINDOW_LIMIT, CSR_DATA_W'($urandom_range(1023, 1)));
      queue_transfer(210, 1'b0);
      wait_idle();

      write_csr(CSR_PACKET_COUNT, CSR_DATA_W'(MAX_PACKETS));
      write_csr(CSR_WINDOW_LIMIT, CSR_DATA_W'($urandom_range(1023, 1)));
      queue_transfer(210, 1'b0);
      wait_idle();

      write_csr(CSR_PACKET_COUNT, CSR_DATA_W'(300));
      write_csr(CSR_WINDOW_LIMIT, CSR_DATA_W'(0));
      queue_transfer(200, 1'b0);
      wait_idle();

      $display("Checked %0d ack responses: %0d ignored, %0d window halvings, final base %0d",
               reports_seen, ignored_seen, losses_seen, pred_base);
      $display("Register settings swept packet count 0..2047 and window limit 0..1023");
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
